>>> hw/rtl/pwch_pkg.sv
// shared types, register indexes and constants of the pixel clamp histogram block
`timescale 1ns / 1ps
`default_nettype none

package pwch_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ADJUST_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HISTO_HEIGHT  = 3'd5;

    // register widths and reset values
    localparam int GAIN_W   = 16;
    localparam int BRIGHT_W = 9;
    localparam int DIM_W    = 13;
    localparam int HISTO_W  = 16;

    localparam logic [GAIN_W-1:0]   GAIN_RESET         = 16'd4096;
    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET       = 9'd0;
    localparam logic [DIM_W-1:0]    IMAGE_WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0]    IMAGE_HEIGHT_RESET = 13'd480;
    localparam logic [HISTO_W-1:0]  HISTO_HEIGHT_RESET = 16'd256;

    // payload widths
    localparam int SAMPLE_W = 16;
    localparam int BIN_W    = 8;
    localparam int NUM_BINS = 256;
    localparam int KIND_W   = 2;
    localparam int POS_W    = 12;

    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOW  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HIGH = 2'd2;

    // Q4.12 scaling
    localparam int PROD_W  = 32;
    localparam int FRAC_W  = 12;
    localparam int VAL_W   = 22;

    // histogram counts and normalization
    localparam int COUNT_W = 24;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 24'hFFFFFF;
    localparam int BPROD_W = COUNT_W + HISTO_W;
    localparam int NUM_W   = BPROD_W + 2;
    localparam int DEN_W   = COUNT_W + 1;
    localparam int QUOT_W  = 16;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_in;
        logic mul;
        logic clamp;
        logic pix_read;
        logic pix_update;
        logic bin_read;
        logic bin_mul;
        logic div_start;
        logic bin_out;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic out_free;
        logic div_done;
    } status_t;

endpackage

`default_nettype wire

>>> hw/rtl/pwch_div.sv
// restoring divider for the bin normalization, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module pwch_div
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [pwch_pkg::NUM_W-1:0]   num,
    input  wire logic [pwch_pkg::DEN_W-1:0]   den,
    output logic                              done,
    output logic      [pwch_pkg::QUOT_W-1:0]  quot
);

    localparam int DSH_W  = pwch_pkg::DEN_W + pwch_pkg::QUOT_W - 1;
    localparam int STEP_W = $clog2(pwch_pkg::QUOT_W + 1);

    logic [pwch_pkg::NUM_W-1:0]  rem_reg;
    logic [DSH_W-1:0]            dsh_reg;
    logic [pwch_pkg::QUOT_W-1:0] quot_reg;
    logic [STEP_W-1:0]           step_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic                        fits;

    assign fits = rem_reg >= pwch_pkg::NUM_W'(dsh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(pwch_pkg::QUOT_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            dsh_reg <= {den, {(pwch_pkg::QUOT_W-1){1'b0}}};
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - pwch_pkg::NUM_W'(dsh_reg);
            end
            quot_reg <= {quot_reg[pwch_pkg::QUOT_W-2:0], fits};
            dsh_reg  <= dsh_reg >> 1;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

>>> hw/rtl/pwch_dp.sv
// datapath: config registers, scaling and clamp, histogram memory, position, output register
`timescale 1ns / 1ps
`default_nettype none

module pwch_dp
#(
    parameter int MAX_WIDTH  = pwch_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = pwch_pkg::DEF_MAX_HEIGHT
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [pwch_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pwch_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire pwch_pkg::cmd_t                    cmd,
    output pwch_pkg::status_t                      status,
    input  wire logic                              req_type,
    input  wire logic [pwch_pkg::SAMPLE_W-1:0]     sample,
    input  wire logic                              frame_start,
    input  wire logic [pwch_pkg::BIN_W-1:0]        bin_index,
    input  wire logic                              out_stall,
    output logic                                   out_valid,
    output logic      [pwch_pkg::BIN_W-1:0]        display_pixel,
    output logic      [pwch_pkg::KIND_W-1:0]       overflow_kind,
    output logic      [pwch_pkg::POS_W-1:0]        pos_x,
    output logic      [pwch_pkg::POS_W-1:0]        pos_y,
    output logic      [pwch_pkg::HISTO_W-1:0]      bin_height
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int XW = ((CW > pwch_pkg::DIM_W) ? CW : pwch_pkg::DIM_W) + 1;
    localparam int YW = ((RW > pwch_pkg::DIM_W) ? RW : pwch_pkg::DIM_W) + 1;

    // configuration
    logic                                adjust_reg;
    logic        [pwch_pkg::GAIN_W-1:0]  gain_reg;
    logic signed [pwch_pkg::BRIGHT_W-1:0] brightness_reg;
    logic        [pwch_pkg::DIM_W-1:0]   image_width_reg;
    logic        [pwch_pkg::DIM_W-1:0]   image_height_reg;
    logic        [pwch_pkg::HISTO_W-1:0] histo_height_reg;

    // item and pipeline registers
    logic signed [pwch_pkg::SAMPLE_W-1:0] sample_reg;
    logic        [pwch_pkg::BIN_W-1:0]    bin_index_reg;
    logic        [pwch_pkg::PROD_W-1:0]   prod_reg;
    logic        [pwch_pkg::BIN_W-1:0]    byte_reg;
    logic        [pwch_pkg::KIND_W-1:0]   kind_reg;
    logic        [pwch_pkg::COUNT_W-1:0]  rdata_reg;
    logic                                 rvalid_reg;
    logic        [pwch_pkg::BPROD_W-1:0]  bprod_reg;

    // histogram state
    logic [pwch_pkg::COUNT_W-1:0]  count_mem [pwch_pkg::NUM_BINS];
    logic [pwch_pkg::NUM_BINS-1:0] valid_bits_reg;
    logic [pwch_pkg::COUNT_W-1:0]  max_count_reg;
    logic [CW-1:0]                 col_reg;
    logic [RW-1:0]                 row_reg;

    // output register
    logic                          out_valid_reg;
    logic [pwch_pkg::BIN_W-1:0]    display_pixel_reg;
    logic [pwch_pkg::KIND_W-1:0]   overflow_kind_reg;
    logic [pwch_pkg::POS_W-1:0]    pos_x_reg;
    logic [pwch_pkg::POS_W-1:0]    pos_y_reg;
    logic [pwch_pkg::HISTO_W-1:0]  bin_height_reg;

    logic                              out_free;
    logic                              frame_clear;
    logic [pwch_pkg::SAMPLE_W-1:0]     mag_next;
    logic signed [pwch_pkg::VAL_W-1:0] q_ext;
    logic signed [pwch_pkg::VAL_W-1:0] value;
    logic [pwch_pkg::BIN_W-1:0]        byte_next;
    logic [pwch_pkg::KIND_W-1:0]       kind_next;
    logic [pwch_pkg::BIN_W-1:0]        rd_addr;
    logic [pwch_pkg::COUNT_W-1:0]      old_count;
    logic [pwch_pkg::COUNT_W-1:0]      count_next;
    logic [pwch_pkg::HISTO_W-1:0]      hm1;
    logic [XW-1:0]                     col_ext;
    logic [YW-1:0]                     row_ext;
    logic                              col_wrap;
    logic                              row_wrap;
    logic [pwch_pkg::NUM_W-1:0]        div_num;
    logic [pwch_pkg::DEN_W-1:0]        div_den;
    logic                              div_done;
    logic [pwch_pkg::QUOT_W-1:0]       div_quot;

    assign out_free    = !out_valid_reg || !out_stall;
    assign frame_clear = cmd.load_in && !req_type && frame_start;

    always_comb
    begin
        status.out_free = out_free;
        status.div_done = div_done;
    end

    // magnitude of the sample, the most negative value maps to 0x8000
    assign mag_next = sample_reg[pwch_pkg::SAMPLE_W-1] ? (~sample_reg + 1'b1) : sample_reg;

    // truncation toward zero: drop fraction bits of the magnitude, then restore the sign
    always_comb
    begin
        q_ext = pwch_pkg::VAL_W'(prod_reg[pwch_pkg::PROD_W-1:pwch_pkg::FRAC_W]);
        if (adjust_reg)
        begin
            value = (sample_reg[pwch_pkg::SAMPLE_W-1] ? -q_ext : q_ext)
                    + pwch_pkg::VAL_W'(brightness_reg);
        end
        else
        begin
            value = pwch_pkg::VAL_W'(sample_reg);
        end

        if (value < -pwch_pkg::VAL_W'(signed'(128)))
        begin
            byte_next = '0;
            kind_next = pwch_pkg::KIND_LOW;
        end
        else if (value > pwch_pkg::VAL_W'(signed'(127)))
        begin
            byte_next = '1;
            kind_next = pwch_pkg::KIND_HIGH;
        end
        else
        begin
            // adding 0x80 to a value in -128..127 flips bit 7
            byte_next = {~value[7], value[6:0]};
            kind_next = pwch_pkg::KIND_NONE;
        end

        if (!adjust_reg)
        begin
            kind_next = pwch_pkg::KIND_NONE;
        end
    end

    assign rd_addr    = cmd.bin_read ? bin_index_reg : byte_reg;
    assign old_count  = rvalid_reg ? rdata_reg : '0;
    assign count_next = (old_count == pwch_pkg::COUNT_MAX) ? old_count : old_count + 1'b1;
    assign hm1        = (histo_height_reg == '0) ? '0 : histo_height_reg - 1'b1;

    assign col_ext  = XW'(col_reg);
    assign row_ext  = YW'(row_reg);
    assign col_wrap = (col_ext + 1'b1 >= XW'(image_width_reg))
                      || (col_reg >= CW'(MAX_WIDTH - 1));
    assign row_wrap = (row_ext + 1'b1 >= YW'(image_height_reg))
                      || (row_reg >= RW'(MAX_HEIGHT - 1));

    assign div_num = {bprod_reg, 1'b0} + pwch_pkg::NUM_W'(max_count_reg);
    assign div_den = {max_count_reg, 1'b0};

    pwch_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adjust_reg       <= 1'b0;
            gain_reg         <= pwch_pkg::GAIN_RESET;
            brightness_reg   <= pwch_pkg::BRIGHT_RESET;
            image_width_reg  <= pwch_pkg::IMAGE_WIDTH_RESET;
            image_height_reg <= pwch_pkg::IMAGE_HEIGHT_RESET;
            histo_height_reg <= pwch_pkg::HISTO_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                pwch_pkg::REG_ADJUST_ENABLE: adjust_reg       <= cfg_data[0];
                pwch_pkg::REG_GAIN:          gain_reg         <= cfg_data;
                pwch_pkg::REG_BRIGHTNESS:    brightness_reg   <= cfg_data[pwch_pkg::BRIGHT_W-1:0];
                pwch_pkg::REG_IMAGE_WIDTH:   image_width_reg  <= cfg_data[pwch_pkg::DIM_W-1:0];
                pwch_pkg::REG_IMAGE_HEIGHT:  image_height_reg <= cfg_data[pwch_pkg::DIM_W-1:0];
                pwch_pkg::REG_HISTO_HEIGHT:  histo_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // datapath payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            sample_reg    <= sample;
            bin_index_reg <= bin_index;
        end
        if (cmd.mul)
        begin
            prod_reg <= pwch_pkg::PROD_W'(mag_next) * pwch_pkg::PROD_W'(gain_reg);
        end
        if (cmd.clamp)
        begin
            byte_reg <= byte_next;
            kind_reg <= kind_next;
        end
        if (cmd.pix_read || cmd.bin_read)
        begin
            rdata_reg  <= count_mem[rd_addr];
            rvalid_reg <= valid_bits_reg[rd_addr];
        end
        if (cmd.bin_mul)
        begin
            bprod_reg <= pwch_pkg::BPROD_W'(old_count) * pwch_pkg::BPROD_W'(hm1);
        end
    end

    // histogram counts
    always_ff @(posedge clk)
    begin
        if (cmd.pix_update)
        begin
            count_mem[byte_reg] <= count_next;
        end
    end

    // valid bits, running maximum and raster position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_bits_reg <= '0;
            max_count_reg  <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
        end
        else if (frame_clear)
        begin
            valid_bits_reg <= '0;
            max_count_reg  <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
        end
        else if (cmd.pix_update)
        begin
            valid_bits_reg[byte_reg] <= 1'b1;
            if (count_next > max_count_reg)
            begin
                max_count_reg <= count_next;
            end
            if (col_wrap)
            begin
                col_reg <= '0;
                row_reg <= row_wrap ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.pix_update || cmd.bin_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pix_update)
        begin
            display_pixel_reg <= byte_reg;
            overflow_kind_reg <= kind_reg;
            pos_x_reg         <= col_ext[pwch_pkg::POS_W-1:0];
            pos_y_reg         <= row_ext[pwch_pkg::POS_W-1:0];
            bin_height_reg    <= '0;
        end
        else if (cmd.bin_out)
        begin
            display_pixel_reg <= '0;
            overflow_kind_reg <= pwch_pkg::KIND_NONE;
            pos_x_reg         <= '0;
            pos_y_reg         <= '0;
            bin_height_reg    <= (max_count_reg == '0) ? '0 : div_quot;
        end
    end

    assign out_valid     = out_valid_reg;
    assign display_pixel = display_pixel_reg;
    assign overflow_kind = overflow_kind_reg;
    assign pos_x         = pos_x_reg;
    assign pos_y         = pos_y_reg;
    assign bin_height    = bin_height_reg;

    // a bin word carries nothing in the pixel fields
    a_bin_word_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (bin_height_reg != '0) |->
            (display_pixel_reg == '0) && (overflow_kind_reg == pwch_pkg::KIND_NONE)
            && (pos_x_reg == '0) && (pos_y_reg == '0))
        else $error("bin word with nonzero pixel fields");

    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (overflow_kind_reg != 2'd3))
        else $error("overflow kind out of range");

    a_max_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pix_update |=> (max_count_reg != '0))
        else $error("running maximum zero after a pixel");

    // normalized height never exceeds the display height minus one
    a_height_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.bin_out |=> (bin_height_reg <= $past(hm1)))
        else $error("bin height above display range");

endmodule

`default_nettype wire

>>> hw/rtl/pwch_ctrl.sv
// controller: sequences pixel and bin read words through the datapath
`timescale 1ns / 1ps
`default_nettype none

module pwch_ctrl
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                req_type,
    output logic                     in_stall,
    input  wire pwch_pkg::status_t   status,
    output pwch_pkg::cmd_t           cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_CLAMP,
        S_PREAD,
        S_PUPD,
        S_BREAD,
        S_BMUL,
        S_BSTART,
        S_BDIV,
        S_BOUT
    } state_t;

    state_t state_reg;
    logic   in_stall_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg    <= req_type ? S_BREAD : S_MUL;
                        in_stall_reg <= 1'b1;
                    end
                end
                S_MUL:   state_reg <= S_CLAMP;
                S_CLAMP: state_reg <= S_PREAD;
                S_PREAD: state_reg <= S_PUPD;
                S_PUPD:
                begin
                    if (status.out_free)
                    begin
                        state_reg    <= S_IDLE;
                        in_stall_reg <= 1'b0;
                    end
                end
                S_BREAD:  state_reg <= S_BMUL;
                S_BMUL:   state_reg <= S_BSTART;
                S_BSTART: state_reg <= S_BDIV;
                S_BDIV:
                begin
                    if (status.div_done)
                    begin
                        state_reg <= S_BOUT;
                    end
                end
                S_BOUT:
                begin
                    if (status.out_free)
                    begin
                        state_reg    <= S_IDLE;
                        in_stall_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg    <= S_IDLE;
                    in_stall_reg <= 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:   cmd.load_in    = in_valid;
            S_MUL:    cmd.mul        = 1'b1;
            S_CLAMP:  cmd.clamp      = 1'b1;
            S_PREAD:  cmd.pix_read   = 1'b1;
            S_PUPD:   cmd.pix_update = status.out_free;
            S_BREAD:  cmd.bin_read   = 1'b1;
            S_BMUL:   cmd.bin_mul    = 1'b1;
            S_BSTART: cmd.div_start  = 1'b1;
            S_BOUT:   cmd.bin_out    = status.out_free;
            default: ;
        endcase
    end

    assign in_stall = in_stall_reg;

    // the divider only finishes while the controller waits for it
    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (state_reg == S_BDIV))
        else $error("divider done outside of wait");

    // a new word is taken only when nothing is in flight
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |=> (state_reg == S_MUL || state_reg == S_BREAD) && in_stall_reg)
        else $error("accepted word did not start a sequence");

endmodule

`default_nettype wire

>>> hw/rtl/pixel_window_clamp_histogram.sv
// Pixel gain/offset clamp with a 256-bin histogram and normalized bin reads.
//
// Input channel (in_valid / in_stall): one word is either a pixel sample
// (req_type 0) or a request to read one normalized histogram bin (req_type 1).
// Output channel (out_valid / out_stall): exactly one word per input word, in
// order. A pixel word carries display_pixel, overflow_kind, pos_x and pos_y;
// a bin word carries bin_height.
// A pixel passes the multiply, clamp, memory read and read-modify-write of the
// count memory, each one step; the read-modify-write step also registers the
// result, and the block accepts the next word once that step is done.
// A bin read passes a memory read, a multiply and the 16-step restoring divider
// that computes round(count * (histo_height - 1) / max), then the output step.
// The next word is accepted while a finished result still waits in the output
// register; when out_stall holds the result, the following word stops at the
// last step before the output register until the register is free.
// frame_start on a pixel clears the histogram through per-bin valid bits at
// once, with no clearing pass. Reset clears the histogram, the
// position and loads the register defaults; the block is ready right after.
// The user must write configuration registers through cfg_write / cfg_index /
// cfg_data only while the block is idle; the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module pixel_window_clamp_histogram
#(
    parameter int MAX_WIDTH  = pwch_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = pwch_pkg::DEF_MAX_HEIGHT
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    input  wire logic                             cfg_write,
    input  wire logic [pwch_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pwch_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic                             req_type,
    input  wire logic [pwch_pkg::SAMPLE_W-1:0]    sample,
    input  wire logic                             frame_start,
    input  wire logic [pwch_pkg::BIN_W-1:0]       bin_index,

    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic      [pwch_pkg::BIN_W-1:0]       display_pixel,
    output logic      [pwch_pkg::KIND_W-1:0]      overflow_kind,
    output logic      [pwch_pkg::POS_W-1:0]       pos_x,
    output logic      [pwch_pkg::POS_W-1:0]       pos_y,
    output logic      [pwch_pkg::HISTO_W-1:0]     bin_height
);

    pwch_pkg::cmd_t    cmd;
    pwch_pkg::status_t status;

    pwch_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    pwch_dp
    #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .status        (status),
        .req_type      (req_type),
        .sample        (sample),
        .frame_start   (frame_start),
        .bin_index     (bin_index),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .display_pixel (display_pixel),
        .overflow_kind (overflow_kind),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .bin_height    (bin_height)
    );

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// testbench for the pixel clamp histogram block: predicted results checked against the stream
`timescale 1ns / 1ps

module tb;
    import pwch_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 30;
    localparam int PHASE_WORDS    = 305;
    localparam int MODEL_MAX_W    = DEF_MAX_WIDTH;
    localparam int MODEL_MAX_H    = DEF_MAX_HEIGHT;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct {
        logic [BIN_W-1:0]   disp;
        logic [KIND_W-1:0]  kind;
        logic [POS_W-1:0]   px;
        logic [POS_W-1:0]   py;
        logic [HISTO_W-1:0] height;
    } out_word_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_write     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  in_valid      = 1'b0;
    logic                  in_stall;
    logic                  req_type      = 1'b0;
    logic [SAMPLE_W-1:0]   sample        = '0;
    logic                  frame_start   = 1'b0;
    logic [BIN_W-1:0]      bin_index     = '0;
    logic                  out_valid;
    logic                  out_stall     = 1'b0;
    logic [BIN_W-1:0]      display_pixel;
    logic [KIND_W-1:0]     overflow_kind;
    logic [POS_W-1:0]      pos_x;
    logic [POS_W-1:0]      pos_y;
    logic [HISTO_W-1:0]    bin_height;

    // predictor copy of the registers and the histogram
    logic                  m_adj_on;
    logic [GAIN_W-1:0]     m_gain;
    logic signed [BRIGHT_W-1:0] m_bright;
    logic [DIM_W-1:0]      m_width;
    logic [DIM_W-1:0]      m_height;
    logic [HISTO_W-1:0]    m_histo;
    logic [COUNT_W-1:0]    hist_count [NUM_BINS];
    bit                    hist_valid [NUM_BINS];
    logic [COUNT_W-1:0]    hist_peak;
    int                    cur_col;
    int                    cur_row;
    logic [BIN_W-1:0]      last_disp;

    out_word_t pending_outputs[$];
    int        fail_count  = 0;
    bit        steady_flow = 1'b0;

    pixel_window_clamp_histogram i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .sample       (sample),
        .frame_start  (frame_start),
        .bin_index    (bin_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .display_pixel(display_pixel),
        .overflow_kind(overflow_kind),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .bin_height   (bin_height)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic reset_model();
        m_adj_on   = 1'b0;
        m_gain     = GAIN_RESET;
        m_bright   = BRIGHT_RESET;
        m_width    = IMAGE_WIDTH_RESET;
        m_height   = IMAGE_HEIGHT_RESET;
        m_histo    = HISTO_HEIGHT_RESET;
        hist_valid = '{default: 0};
        hist_count = '{default: '0};
        hist_peak  = '0;
        cur_col    = 0;
        cur_row    = 0;
        last_disp  = '0;
    endtask

    // works out the result of one accepted word and, for a pixel, updates the histogram
    task automatic model_word(input logic rq, input logic [SAMPLE_W-1:0] smp,
                              input logic fs, input logic [BIN_W-1:0] bidx);
        out_word_t r;
        longint    s;
        longint    v;
        longint    mag;
        longint    q;
        longint    cnt;
        longint    hm1;
        longint    h;
        int        b;
        begin
            r = '{disp: '0, kind: KIND_NONE, px: '0, py: '0, height: '0};
            if (rq)
            begin
                cnt = hist_valid[bidx] ? longint'(hist_count[bidx]) : 0;
                hm1 = (m_histo != 0) ? longint'(m_histo) - 1 : 0;
                h   = 0;
                if (hist_peak != 0)
                    h = (2 * cnt * hm1 + longint'(hist_peak)) / (2 * longint'(hist_peak));
                r.height = 16'(h);
            end
            else
            begin
                if (fs)
                begin
                    hist_valid = '{default: 0};
                    hist_peak  = '0;
                    cur_col    = 0;
                    cur_row    = 0;
                end
                s = longint'($signed(smp));
                v = s;
                if (m_adj_on)
                begin
                    mag = ((s < 0) ? -s : s) * longint'(m_gain);
                    q   = mag >>> FRAC_W;
                    v   = ((s < 0) ? -q : q) + longint'(m_bright);
                end
                if (v < -128)
                begin
                    b      = 0;
                    r.kind = KIND_LOW;
                end
                else if (v > 127)
                begin
                    b      = 255;
                    r.kind = KIND_HIGH;
                end
                else
                    b = int'(v) + 128;
                if (!m_adj_on)
                    r.kind = KIND_NONE;

                if (hist_valid[b])
                begin
                    if (hist_count[b] < COUNT_MAX)
                        hist_count[b] = hist_count[b] + 1'b1;
                end
                else
                begin
                    hist_valid[b] = 1'b1;
                    hist_count[b] = 24'd1;
                end
                if (hist_count[b] > hist_peak)
                    hist_peak = hist_count[b];

                r.disp    = 8'(b);
                r.px      = 12'(cur_col);
                r.py      = 12'(cur_row);
                last_disp = 8'(b);

                // raster advance, wrapping on the register or the maximum size
                if (cur_col + 1 >= int'(m_width) || cur_col >= MODEL_MAX_W - 1)
                begin
                    cur_col = 0;
                    if (cur_row + 1 >= int'(m_height) || cur_row >= MODEL_MAX_H - 1)
                        cur_row = 0;
                    else
                        cur_row = cur_row + 1;
                end
                else
                    cur_col = cur_col + 1;
            end
            pending_outputs.push_back(r);
        end
    endtask

    function automatic int pick_gap();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (steady_flow || r < 55)
                return 0;
            if (r < 92)
                return $urandom_range(1, 3);
            return $urandom_range(8, 40);
        end
    endfunction

    task automatic send_word(input logic rq, input logic [SAMPLE_W-1:0] smp,
                             input logic fs, input logic [BIN_W-1:0] bidx);
        int gap;
        begin
            in_valid    <= 1'b1;
            req_type    <= rq;
            sample      <= smp;
            frame_start <= fs;
            bin_index   <= bidx;
            @(posedge clk);
            while (!(in_valid && !in_stall))
                @(posedge clk);
            model_word(rq, smp, fs, bidx);
            gap = pick_gap();
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_pixel(input logic [SAMPLE_W-1:0] smp, input logic fs);
        send_word(1'b0, smp, fs, 8'($urandom));
    endtask

    task automatic send_read(input logic [BIN_W-1:0] bidx, input logic fs);
        send_word(1'b1, 16'($urandom), fs, bidx);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_ADJUST_ENABLE: m_adj_on = data[0];
            REG_GAIN:          m_gain   = data[GAIN_W-1:0];
            REG_BRIGHTNESS:    m_bright = data[BRIGHT_W-1:0];
            REG_IMAGE_WIDTH:   m_width  = data[DIM_W-1:0];
            REG_IMAGE_HEIGHT:  m_height = data[DIM_W-1:0];
            REG_HISTO_HEIGHT:  m_histo  = data[HISTO_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic adj, input logic [GAIN_W-1:0] g,
                                  input logic [BRIGHT_W-1:0] br, input logic [DIM_W-1:0] w,
                                  input logic [DIM_W-1:0] h, input logic [HISTO_W-1:0] hh);
        wait_idle();
        write_reg(REG_ADJUST_ENABLE, 16'(adj));
        write_reg(REG_GAIN, g);
        write_reg(REG_BRIGHTNESS, 16'(br));
        write_reg(REG_IMAGE_WIDTH, 16'(w));
        write_reg(REG_IMAGE_HEIGHT, 16'(h));
        write_reg(REG_HISTO_HEIGHT, hh);
    endtask

    task automatic send_random_word();
        int r;
        int n;
        begin
            r = $urandom_range(0, 99);
            if (r < 18)
            begin
                // one read in four targets the bin just filled, the others a random bin
                if ($urandom_range(0, 3) == 0)
                    send_read(last_disp, 1'($urandom));
                else
                    send_read(8'($urandom), 1'($urandom));
            end
            else
            begin
                n = $urandom_range(0, 99);
                if (n < 55)
                    send_pixel(16'($urandom_range(0, 280) - 140), $urandom_range(0, 99) < 3);
                else
                    send_pixel(16'($urandom), $urandom_range(0, 99) < 3);
            end
        end
    endtask

    // empty histogram first, frame_start on a read ignored, then raw clamping
    task automatic test_reset_defaults();
        send_read(8'd0, 1'b0);
        send_read(8'd255, 1'b1);
        send_pixel(16'h8000, 1'b1);
        send_pixel(16'h7FFF, 1'b0);
        send_read(8'd0, 1'b0);
        send_read(8'd255, 1'b0);
    endtask

    task automatic test_clamp_extremes();
        apply_settings(1'b1, 16'hFFFF, 9'h0FF, 13'd640, 13'd480, 16'd0);
        // writes to unused indexes must leave every register alone
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'h0000);
        send_pixel(16'h8000, 1'b1);
        send_pixel(16'h7FFF, 1'b0);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'hFFFF, 1'b0);
        send_read(8'd255, 1'b0);
        apply_settings(1'b1, 16'd4096, 9'h100, 13'd640, 13'd480, 16'hFFFF);
        send_pixel(16'd383, 1'b1);
        send_pixel(16'd384, 1'b0);
        send_pixel(16'd128, 1'b0);
        send_pixel(16'd127, 1'b0);
        send_read(8'd0, 1'b0);
        send_read(8'd255, 1'b0);
    endtask

    task automatic test_position_wrap();
        int k;
        begin
            apply_settings(1'b0, 16'd4096, 9'd0, 13'd3, 13'd2, 16'd256);
            for (k = 0; k < 7; k++)
                send_pixel(16'(k), k == 0);
            apply_settings(1'b0, 16'd4096, 9'd0, 13'd0, 13'd0, 16'd256);
            send_pixel(16'd5, 1'b0);
            send_pixel(16'd6, 1'b0);
        end
    endtask

    task automatic test_random_phases();
        int p;
        int k;
        begin
            for (p = 0; p < 6; p++)
            begin
                case (p)
                    0: apply_settings(1'b1, 16'd0, 9'h100, 13'd1, 13'd1, 16'd1);
                    1: apply_settings(1'b1, 16'hFFFF, 9'h0FF, 13'd4096, 13'd4096, 16'hFFFF);
                    2: apply_settings(1'b0, 16'($urandom), 9'($urandom), 13'd0, 13'd0, 16'd0);
                    3: apply_settings(1'b1, 16'($urandom_range(2048, 8192)), 9'($urandom),
                                      13'($urandom_range(1, 16)), 13'($urandom_range(1, 8)),
                                      16'($urandom));
                    4: apply_settings(1'b1, 16'($urandom), 9'($urandom), 13'h1FFF,
                                      13'($urandom_range(1, 8)), 16'($urandom));
                    default: apply_settings(1'($urandom), 16'($urandom), 9'($urandom),
                                            13'($urandom_range(1, 40)),
                                            13'($urandom_range(1, 10)), 16'($urandom));
                endcase
                // one phase runs with no gaps on either side
                steady_flow = (p == 2);
                for (k = 0; k < PHASE_WORDS; k++)
                    send_random_word();
                steady_flow = 1'b0;
            end
        end
    endtask

    task automatic check_field(input string name, input int expv, input int gotv);
        if (expv != gotv)
        begin
            $error("%s expected %0d got %0d", name, expv, gotv);
            fail_count++;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_outputs.size() == 0)
            begin
                $error("result word with nothing expected");
                fail_count++;
            end
            else
            begin
                e = pending_outputs.pop_front();
                check_field("display_pixel", e.disp, display_pixel);
                check_field("overflow_kind", e.kind, overflow_kind);
                check_field("pos_x", e.px, pos_x);
                check_field("pos_y", e.py, pos_y);
                check_field("bin_height", e.height, bin_height);
            end
        end
    end

    // receiver stalls
    initial
    begin
        int r;
        int len;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            r = $urandom_range(0, 99);
            if (steady_flow || r < 70)
                out_stall <= 1'b0;
            else
            begin
                len = (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 40);
                out_stall <= 1'b1;
                repeat (len) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no word moving on either channel
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        reset_model();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_clamp_extremes();
        test_position_wrap();
        test_random_phases();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
